### src/slbc_pkg.sv
// Shared types and constants for the status LED blink code unit.
package slbc_pkg;

	localparam int NOW_W         = 32;
	localparam int ERR_IN_W      = 8;
	localparam int SHOWN_W       = 4;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int ERROR_BITS_DEF = 8;
	localparam int CODE_OFFSET   = 2;

	localparam logic [CFG_DATA_W-1:0] OTA_HALF_RST = 16'd100;
	localparam logic [CFG_DATA_W-1:0] BLINK_RST    = 16'd250;
	localparam logic [CFG_DATA_W-1:0] PAUSE_RST    = 16'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OTA_MODE  = 2'd0,
		REG_OTA_HALF  = 2'd1,
		REG_BLINK     = 2'd2,
		REG_PAUSE     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                  ota_mode;
		logic [CFG_DATA_W-1:0] ota_half_period_ms;
		logic [CFG_DATA_W-1:0] blink_period_ms;
		logic [CFG_DATA_W-1:0] burst_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic               led_on;
		logic [SHOWN_W-1:0] shown_code;
		logic               in_pause;
	} res_t;

endpackage

### src/slbc_cfg_regs.sv
// Configuration register file of the status LED blink code unit.
module slbc_cfg_regs
	import slbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ota_mode           <= 1'b0;
			cfg_q.ota_half_period_ms <= OTA_HALF_RST;
			cfg_q.blink_period_ms    <= BLINK_RST;
			cfg_q.burst_gap_ms       <= PAUSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_OTA_MODE: cfg_q.ota_mode           <= cfg_data[0];
				REG_OTA_HALF: cfg_q.ota_half_period_ms <= cfg_data;
				REG_BLINK:    cfg_q.blink_period_ms    <= cfg_data;
				REG_PAUSE:    cfg_q.burst_gap_ms       <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### src/slbc_engine.sv
// Display state and per-tick update of the status LED blink code unit.
module slbc_engine
	import slbc_pkg::*;
#(
	parameter int ERROR_BITS = ERROR_BITS_DEF
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  cfg_t                cfg,
	input  logic [NOW_W-1:0]    now_ms,
	input  logic [ERR_IN_W-1:0] error_bits,
	input  logic                valve_active,
	output res_t                res
);

	localparam int EFF_BITS = (ERROR_BITS < ERR_IN_W) ? ERROR_BITS : ERR_IN_W;
	localparam int CODE_W   = $clog2(EFF_BITS + CODE_OFFSET);
	localparam int STEP_W   = $clog2(2 * (EFF_BITS + 1) + 1);

	logic              valve_seen_q, lamp_lit_q, code_valid_q;
	logic [NOW_W-1:0]  last_change_q;
	logic [CODE_W-1:0] code_q;
	logic [STEP_W-1:0] burst_step_q;

	logic              vs_d, lit_d, cv_d;
	logic [NOW_W-1:0]  last_d, diff;
	logic [CODE_W-1:0] code_d, code;
	logic [STEP_W-1:0] bs_d, steps;
	logic              pausing;

	// Lowest set error bit gives its code; no error gives the heartbeat.
	always_comb begin
		code = '0;
		for (int i = EFF_BITS - 1; i >= 0; i--) begin
			if (error_bits[i]) begin
				code = CODE_W'(i + CODE_OFFSET);
			end
		end
	end

	always_comb begin
		vs_d    = valve_seen_q;
		lit_d   = lamp_lit_q;
		cv_d    = code_valid_q;
		last_d  = last_change_q;
		code_d  = code_q;
		bs_d    = burst_step_q;
		pausing = 1'b0;
		steps   = (code == '0) ? STEP_W'(2) : STEP_W'({code, 1'b0});

		if (valve_active != valve_seen_q) begin
			vs_d = valve_active;
			if (valve_active) begin
				lit_d = 1'b1;
			end else begin
				cv_d  = 1'b0;
				lit_d = 1'b0;
			end
		end

		// Restart the burst on a new code, or when no code is held (after reset or a valve phase).
		if (!cfg.ota_mode && !vs_d && (!cv_d || code != code_d)) begin
			code_d = code;
			cv_d   = 1'b1;
			bs_d   = '0;
			last_d = now_ms;
			lit_d  = 1'b0;
		end

		diff = now_ms - last_d;

		if (cfg.ota_mode) begin
			if (diff >= NOW_W'(cfg.ota_half_period_ms)) begin
				last_d = now_ms;
				lit_d  = ~lit_d;
			end
		end else if (!vs_d) begin
			if (bs_d < steps) begin
				if (diff >= NOW_W'(cfg.blink_period_ms)) begin
					last_d = now_ms;
					lit_d  = ~bs_d[0];
					bs_d   = STEP_W'(bs_d + 1'b1);
				end
			end else begin
				lit_d = 1'b0;
				if (diff >= NOW_W'(cfg.burst_gap_ms)) begin
					last_d = now_ms;
					bs_d   = '0;
				end
			end
			pausing = (bs_d >= steps);
		end

		res.led_on     = lit_d;
		res.shown_code = (!cfg.ota_mode && !vs_d) ? SHOWN_W'(code) : '0;
		res.in_pause   = pausing;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_seen_q  <= 1'b0;
			lamp_lit_q    <= 1'b0;
			code_valid_q  <= 1'b0;
			last_change_q <= '0;
			code_q        <= '0;
			burst_step_q  <= '0;
		end else if (step) begin
			valve_seen_q  <= vs_d;
			lamp_lit_q    <= lit_d;
			code_valid_q  <= cv_d;
			last_change_q <= last_d;
			code_q        <= code_d;
			burst_step_q  <= bs_d;
		end
	end

endmodule

### src/status_led_blink_code_unit.sv
// Top level of the status LED blink code unit.
//
// Usage: while in_stall is low, one tick transaction per clock on the input
// channel (in_valid / in_stall) carries now_ms, error_bits and valve_active.
// Each tick yields exactly one result transaction on the output channel
// (out_valid / out_stall) with led_on, shown_code and in_pause, in tick order.
// Path: an accepted tick is held in the input register; the display update
// then writes state and result register together as the tick moves on to
// the result stage, which a held result on the output can delay.
// Throughput: one tick per cycle while no result is held by out_stall; the
// state loop is a compare of a 32-bit time difference plus a priority encode.
// Stall: while out_stall holds a result, the input register still takes
// one more tick; in_stall rises only when both registers are full.
// Configuration: cfg_valid / cfg_ready writes a register by index; ready
// is always high. Write only while no tick is in flight.
// Reset: arst_n clears the display state and both pipeline valids and
// restores the configuration defaults; the first display tick after reset
// restarts the burst.
module status_led_blink_code_unit
	import slbc_pkg::*;
#(
	parameter int ERROR_BITS = ERROR_BITS_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [NOW_W-1:0]      now_ms,
	input  logic [ERR_IN_W-1:0]   error_bits,
	input  logic                  valve_active,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  led_on,
	output logic [SHOWN_W-1:0]    shown_code,
	output logic                  in_pause,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;

	// Input stage.
	logic                valid_s1;
	logic [NOW_W-1:0]    now_ms_s1;
	logic [ERR_IN_W-1:0] error_bits_s1;
	logic                valve_s1;

	// Result stage.
	logic valid_s2;
	res_t res_s2;

	logic advance;

	// Result register frees up when empty or when its transaction completes.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	slbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Commit a tick to the display state only as it moves to the result stage.
	slbc_engine #(
		.ERROR_BITS (ERROR_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (valid_s1 && advance),
		.cfg          (cfg),
		.now_ms       (now_ms_s1),
		.error_bits   (error_bits_s1),
		.valve_active (valve_s1),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: hold while stalled, load on a completed transaction.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			now_ms_s1     <= now_ms;
			error_bits_s1 <= error_bits;
			valve_s1      <= valve_active;
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign led_on     = res_s2.led_on;
	assign shown_code = res_s2.shown_code;
	assign in_pause   = res_s2.in_pause;

endmodule

### src/slbc_checker.sv
// Port-level checks for the status LED blink code unit, bound to the top.
module slbc_checker
	import slbc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               led_on,
	input logic [SHOWN_W-1:0] shown_code,
	input logic               in_pause
);

	// Back-pressure on input only when a result is held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side is free");

	// A pause keeps the LED dark.
	a_pause_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_pause) |-> !led_on)
		else $error("LED lit during pause");

	// Codes are the heartbeat or an error code in range.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shown_code == 4'd0 ||
			(shown_code >= 4'd2 && shown_code <= 4'd9)))
		else $error("shown_code out of range");

	// A pause with a nonzero code shows an error code of at least 2.
	a_pause_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_pause && shown_code != 4'd0) |-> shown_code >= 4'd2)
		else $error("pause with invalid code");

	// A held result stays valid.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

endmodule

bind status_led_blink_code_unit slbc_checker u_slbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.led_on     (led_on),
	.shown_code (shown_code),
	.in_pause   (in_pause)
);
